// ===== design/lss_pkg.sv =====
// Shared types and constants for the least-squares slope block.
package lss_pkg;

  // Field widths of the point and result items.
  localparam int X_W      = 16;
  localparam int SLOPE_W  = 32;
  localparam int STATUS_W = 2;

  // Accumulator widths.
  localparam int CNT_W  = 11;
  localparam int SX_W   = 27;
  localparam int SXY_W  = 42;
  localparam int SXX_W  = 41;

  // Largest number of points folded into one set.
  localparam int MAX_POINTS = 1024;

  // Scale that turns the quotient into thousandths.
  localparam int SCALE_FACTOR = 1000;

  // Datapath of the shared multiply/divide unit.
  localparam int WORD_W    = 64;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = 7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] FIT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] FIT_DEGENERATE = 2'd1;
  localparam logic [STATUS_W-1:0] FIT_SATURATED  = 2'd2;

  // Operation of the shared unit.
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_t;

  // Request from the sequencer to the shared unit.
  typedef struct packed {
    logic              start;
    unit_op_t          op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } unit_req_t;

  // Response of the shared unit: done pulses for one cycle with the result.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } unit_rsp_t;

endpackage

// ===== design/lss_unit.sv =====
// Shared iterative unit: unsigned shift-add multiply and restoring divide.
module lss_unit (
  input  logic              clk,
  input  logic              rst,
  input  lss_pkg::unit_req_t req,
  output lss_pkg::unit_rsp_t rsp
);
  import lss_pkg::*;

  logic              busy;
  logic              done;
  unit_op_t          op;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [STEP_W-1:0] steps;

  logic              is_div;
  logic [WORD_W-1:0] trial;
  logic [WORD_W-1:0] add_a;
  logic [WORD_W-1:0] add_b;
  logic [WORD_W:0]   sum;

  // One adder serves both operations. In a divide it subtracts the divisor
  // from the shifted remainder, and the carry out says the trial fits.
  always_comb begin
    is_div = (op == OP_DIV);
    trial  = {acc[WORD_W-2:0], opa[WORD_W-1]};
    add_a  = is_div ? trial : acc;
    if (is_div) begin
      add_b = ~opb;
    end else begin
      add_b = opb[0] ? opa : '0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, is_div};
  end

  // Control: busy while steps remain, done pulses after the final step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: multiplicand shifts left and multiplier right; in a divide the
  // dividend shifts out of opa while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      acc   <= '0;
      opa   <= req.a;
      opb   <= req.b;
      steps <= (req.op == OP_DIV) ? STEP_W'(DIV_STEPS) : STEP_W'(MUL_STEPS);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (is_div) begin
        acc <= sum[WORD_W] ? sum[WORD_W-1:0] : trial;
        opa <= {opa[WORD_W-2:0], sum[WORD_W]};
      end else begin
        acc <= sum[WORD_W-1:0];
        opa <= {opa[WORD_W-2:0], 1'b0};
        opb <= {1'b0, opb[WORD_W-1:1]};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op == OP_DIV) ? opa : acc;

endmodule

// ===== design/least_squares_slope_top.sv =====
// Top level of the least-squares slope block: sums, sequencer, result register.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | point: x_value, y_value in tdata, last_point as tlast
//  m_*      | out       | result: slope_milli in tdata, fit_status in tuser
//
// A point folded into the sums takes two 32-step multiplies on the shared unit
// (x*y and x*x). A point marked last adds four 32-step multiplies for the
// cross terms and, unless the denominator is zero, one for the scale by 1000
// and a 64-step divide, plus the wait for the result register. Reset clears
// the sums, the sequencer and the result valid. A stalled result holds in the
// output register while the next point is taken; only the next result waits.
module least_squares_slope_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,  // x_value[15:0], y_value[31:16]
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lss_pkg::SLOPE_W-1:0]   m_tdata,  // slope_milli[31:0]
  output logic [lss_pkg::STATUS_W-1:0]  m_tuser   // fit_status[1:0]
);
  import lss_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_XY    = 10'b00_0000_0010,
    ST_XX    = 10'b00_0000_0100,
    ST_NSXY  = 10'b00_0000_1000,
    ST_SXSY  = 10'b00_0001_0000,
    ST_NSXX  = 10'b00_0010_0000,
    ST_SXSX  = 10'b00_0100_0000,
    ST_SCALE = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Running sums of the current set.
  logic [CNT_W-1:0]        point_count;
  logic signed [SX_W-1:0]  sum_of_x;
  logic signed [SX_W-1:0]  sum_of_y;
  logic signed [SXY_W-1:0] sum_of_xy;
  logic [SXX_W-1:0]        sum_of_xx;

  // Latched point and intermediate terms.
  logic signed [X_W-1:0]    x_reg;
  logic signed [X_W-1:0]    y_reg;
  logic                     last_reg;
  logic signed [WORD_W-1:0] tmp;
  logic signed [WORD_W-1:0] num;
  logic signed [WORD_W-1:0] den;
  logic [SLOPE_W-1:0]       res_slope;
  logic [STATUS_W-1:0]      res_status;
  logic                     issued;

  unit_req_t req;
  unit_rsp_t rsp;

  logic                     neg;
  logic signed [WORD_W-1:0] res_s;
  logic signed [WORD_W-1:0] diff;
  logic signed [WORD_W-1:0] x_ext;
  logic signed [WORD_W-1:0] y_ext;
  logic                     in_accept;
  logic                     has_room;
  logic                     compute;
  logic                     out_free;
  logic                     q_sat;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
  endfunction

  lss_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign has_room  = (point_count < CNT_W'(MAX_POINTS));
  assign out_free  = !m_tvalid || m_tready;
  assign x_ext     = {{(WORD_W-X_W){x_reg[X_W-1]}}, x_reg};
  assign y_ext     = {{(WORD_W-X_W){y_reg[X_W-1]}}, y_reg};

  // Operand selection for the shared unit, one operation per state.
  always_comb begin
    req.op  = OP_MUL;
    req.a   = '0;
    req.b   = '0;
    neg     = 1'b0;
    compute = 1'b1;
    unique case (state)
      ST_XY: begin
        req.a = mag(x_ext);
        req.b = mag(y_ext);
        neg   = x_reg[X_W-1] ^ y_reg[X_W-1];
      end
      ST_XX: begin
        req.a = mag(x_ext);
        req.b = mag(x_ext);
      end
      ST_NSXY: begin
        req.a = mag({{(WORD_W-SXY_W){sum_of_xy[SXY_W-1]}}, sum_of_xy});
        req.b = {{(WORD_W-CNT_W){1'b0}}, point_count};
        neg   = sum_of_xy[SXY_W-1];
      end
      ST_SXSY: begin
        req.a = mag({{(WORD_W-SX_W){sum_of_x[SX_W-1]}}, sum_of_x});
        req.b = mag({{(WORD_W-SX_W){sum_of_y[SX_W-1]}}, sum_of_y});
        neg   = sum_of_x[SX_W-1] ^ sum_of_y[SX_W-1];
      end
      ST_NSXX: begin
        req.a = {{(WORD_W-SXX_W){1'b0}}, sum_of_xx};
        req.b = {{(WORD_W-CNT_W){1'b0}}, point_count};
      end
      ST_SXSX: begin
        req.a = mag({{(WORD_W-SX_W){sum_of_x[SX_W-1]}}, sum_of_x});
        req.b = req.a;
      end
      ST_SCALE: begin
        req.a = mag(num);
        req.b = WORD_W'(SCALE_FACTOR);
      end
      ST_DIV: begin
        req.op = OP_DIV;
        req.a  = tmp;
        req.b  = den;
      end
      ST_IDLE, ST_OUT: begin
        compute = 1'b0;
      end
      default: begin
        compute = 1'b0;
      end
    endcase
    req.start = compute && !issued;
    res_s     = neg ? -signed'(rsp.result) : signed'(rsp.result);
    diff      = tmp - res_s;
  end

  // Saturation of the quotient magnitude against the signed 32-bit range.
  always_comb begin
    if (num[WORD_W-1]) begin
      q_sat = (rsp.result > {{(WORD_W-SLOPE_W){1'b0}}, 1'b1, {(SLOPE_W-1){1'b0}}});
    end else begin
      q_sat = (rsp.result > {{(WORD_W-SLOPE_W+1){1'b0}}, {(SLOPE_W-1){1'b1}}});
    end
  end

  // Sequencer: each compute state waits for the unit's done pulse.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (has_room) begin
            state_next = ST_XY;
          end else if (s_tlast) begin
            state_next = ST_NSXY;
          end
        end
      end
      ST_XY:    if (rsp.done) state_next = ST_XX;
      ST_XX:    if (rsp.done) state_next = last_reg ? ST_NSXY : ST_IDLE;
      ST_NSXY:  if (rsp.done) state_next = ST_SXSY;
      ST_SXSY:  if (rsp.done) state_next = ST_NSXX;
      ST_NSXX:  if (rsp.done) state_next = ST_SXSX;
      ST_SXSX:  if (rsp.done) state_next = (diff == '0) ? ST_OUT : ST_SCALE;
      ST_SCALE: if (rsp.done) state_next = ST_DIV;
      ST_DIV:   if (rsp.done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state, sums and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
      point_count <= '0;
      sum_of_x    <= '0;
      sum_of_y    <= '0;
      sum_of_xy   <= '0;
      sum_of_xx   <= '0;
    end else begin
      state <= state_next;
      if (rsp.done) begin
        issued <= 1'b0;
      end else if (req.start) begin
        issued <= 1'b1;
      end
      // The output register loads a new result, or empties once taken.
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_XX && rsp.done) begin
        point_count <= point_count + CNT_W'(1);
        sum_of_x    <= sum_of_x + SX_W'(x_ext);
        sum_of_y    <= sum_of_y + SX_W'(y_ext);
        sum_of_xy   <= sum_of_xy + tmp[SXY_W-1:0];
        sum_of_xx   <= sum_of_xx + rsp.result[SXX_W-1:0];
      end
      if (state == ST_OUT && out_free) begin
        point_count <= '0;
        sum_of_x    <= '0;
        sum_of_y    <= '0;
        sum_of_xy   <= '0;
        sum_of_xx   <= '0;
      end
    end
  end

  // Payload registers: latched point, intermediate terms and the result.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_reg    <= s_tdata[X_W-1:0];
      y_reg    <= s_tdata[2*X_W-1:X_W];
      last_reg <= s_tlast;
    end
    if (rsp.done) begin
      unique case (state)
        ST_XY, ST_NSXY, ST_NSXX: begin
          tmp <= res_s;
        end
        ST_SCALE: begin
          tmp <= signed'(rsp.result);
        end
        ST_SXSY: begin
          num <= diff;
        end
        ST_SXSX: begin
          den        <= diff;
          res_slope  <= '0;
          res_status <= (diff == '0) ? FIT_DEGENERATE : FIT_OK;
        end
        ST_DIV: begin
          if (q_sat) begin
            res_status <= FIT_SATURATED;
            res_slope  <= num[WORD_W-1] ? {1'b1, {(SLOPE_W-1){1'b0}}}
                                        : {1'b0, {(SLOPE_W-1){1'b1}}};
          end else begin
            res_status <= FIT_OK;
            res_slope  <= num[WORD_W-1] ? -rsp.result[SLOPE_W-1:0]
                                        : rsp.result[SLOPE_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= res_slope;
      m_tuser <= res_status;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the least-squares slope block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int RANDOM_POINTS = 600;
  localparam int DRAIN_CYCLES  = 400;
  localparam int LONG_HOLD_AT  = 30;
  localparam int LONG_HOLD     = 4000;

  typedef struct {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic                  last;
  } point_t;

  typedef struct {
    logic [SLOPE_W-1:0]  slope;
    logic [STATUS_W-1:0] status;
  } fit_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SLOPE_W-1:0]  m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // Points waiting to be sent and fits waiting to come back.
  point_t points_to_send[$];
  fit_t   pending_fits[$];

  // Running sums of the set that is being accumulated.
  logic        [CNT_W-1:0] set_count = '0;
  logic signed [SX_W-1:0]  set_sx    = '0;
  logic signed [SX_W-1:0]  set_sy    = '0;
  logic signed [SXY_W-1:0] set_sxy   = '0;
  logic        [SXX_W-1:0] set_sxx   = '0;

  // Handshakes seen at the last rising edge.
  logic s_taken = 1'b0;
  logic m_taken = 1'b0;

  int     error_count = 0;
  int     cycle_count = 0;
  int     fits_taken  = 0;
  int     send_wait   = 0;
  int     send_mode_left = 0;
  bit     send_quiet  = 1'b0;
  int     recv_wait   = 0;
  int     recv_mode_left = 0;
  bit     recv_quiet  = 1'b0;
  point_t next_point;

  least_squares_slope_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Fold one point into the sums; a point marked last yields the expected fit.
  task automatic accumulate_point(input point_t p);
    longint n, sx, sy, num, den, q;
    fit_t   fit;
    if (set_count < MAX_POINTS) begin
      set_count = set_count + 1'b1;
      set_sx    = set_sx + p.x;
      set_sy    = set_sy + p.y;
      set_sxy   = set_sxy + SXY_W'(longint'(p.x) * longint'(p.y));
      set_sxx   = set_sxx + SXX_W'(longint'(p.x) * longint'(p.x));
    end
    if (p.last) begin
      n   = longint'(set_count);
      sx  = longint'(set_sx);
      sy  = longint'(set_sy);
      num = n * longint'(set_sxy) - sx * sy;
      den = n * longint'(set_sxx) - sx * sx;
      fit.status = FIT_OK;
      if (den == 0) begin
        q = 0;
        fit.status = FIT_DEGENERATE;
      end else begin
        q = (num * SCALE_FACTOR) / den;
        if (q > 64'sd2147483647) begin
          q = 64'sd2147483647;
          fit.status = FIT_SATURATED;
        end else if (q < -64'sd2147483648) begin
          q = -64'sd2147483648;
          fit.status = FIT_SATURATED;
        end
      end
      fit.slope = q[SLOPE_W-1:0];
      pending_fits.push_back(fit);
      set_count = '0;
      set_sx    = '0;
      set_sy    = '0;
      set_sxy   = '0;
      set_sxx   = '0;
    end
  endtask

  function automatic logic signed [X_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[X_W-1:0];
  endfunction

  task automatic add_point(input int x, input int y, input bit last);
    point_t p;
    p.x = x[X_W-1:0];
    p.y = y[X_W-1:0];
    p.last = last;
    points_to_send.push_back(p);
  endtask

  // One random set; the flavor decides how the points are spread.
  task automatic add_random_set(input int len);
    int flavor, slope, offset, x0, x, y;
    flavor = $urandom_range(0, 4);
    slope  = int'($urandom_range(0, 400)) - 200;
    offset = int'($urandom_range(0, 2000)) - 1000;
    x0     = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      case (flavor)
        0: begin
          x = int'($urandom_range(0, 65535)) - 32768;
          y = int'($urandom_range(0, 65535)) - 32768;
        end
        1: begin
          x = int'($urandom_range(0, 20)) - 10;
          y = int'($urandom_range(0, 200)) - 100;
        end
        2: begin
          x = x0;
          y = int'($urandom_range(0, 65535)) - 32768;
        end
        3: begin
          x = int'($urandom_range(0, 300)) - 150;
          y = clip16(slope * x + offset + int'($urandom_range(0, 40)) - 20);
        end
        default: begin
          x = $urandom_range(0, 1) ? 32767 : -32768;
          y = $urandom_range(0, 1) ? 32767 : -32768;
        end
      endcase
      add_point(x, y, i == len - 1);
    end
  endtask

  // Record both handshakes; predict accepted points and check accepted fits.
  always @(posedge clk) begin
    fit_t want;
    cycle_count <= cycle_count + 1;
    s_taken <= s_tvalid && s_tready && !rst;
    m_taken <= m_tvalid && m_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      accumulate_point('{x: s_tdata[15:0], y: s_tdata[31:16], last: s_tlast});
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected fit, expected none, actual slope %0d status %0d",
                 $time, $signed(m_tdata), m_tuser);
        error_count++;
      end else begin
        want = pending_fits.pop_front();
        if (m_tdata !== want.slope) begin
          $display("%0t: slope mismatch, expected %0d, actual %0d",
                   $time, $signed(want.slope), $signed(m_tdata));
          error_count++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, m_tuser);
          error_count++;
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d fits outstanding", $time, pending_fits.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Point driver: a random gap before each item, with stretches of no gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (s_taken) begin
        if (send_mode_left == 0) begin
          send_quiet = ($urandom_range(0, 2) == 0);
          send_mode_left = $urandom_range(20, 80);
        end else begin
          send_mode_left--;
        end
        send_wait = send_quiet ? 0 : $urandom_range(0, 16);
      end
      if (send_wait > 0 || points_to_send.size() == 0) begin
        s_tvalid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end else begin
        next_point = points_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {next_point.y, next_point.x};
        s_tlast  <= next_point.last;
      end
    end
  end

  // Fit receiver: random hold-off after each item, one long hold-off midway.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_taken) begin
        fits_taken++;
        if (recv_mode_left == 0) begin
          recv_quiet = ($urandom_range(0, 2) == 0);
          recv_mode_left = $urandom_range(5, 20);
        end else begin
          recv_mode_left--;
        end
        if (fits_taken == LONG_HOLD_AT) recv_wait = LONG_HOLD;
        else recv_wait = recv_quiet ? 0 : $urandom_range(0, 16);
      end
      if (recv_wait > 0) begin
        m_tready <= 1'b0;
        recv_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int random_points, len;
    // Lone point and equal x values: zero denominator.
    add_point(-32768, 32767, 1);
    add_point(5, 1, 0);
    add_point(5, -32768, 0);
    add_point(5, 32767, 1);
    // Corners of the input range.
    add_point(-32768, -32768, 0);
    add_point(32767, 32767, 0);
    add_point(-32768, 32767, 0);
    add_point(32767, -32768, 1);
    // Steepest slopes either way.
    add_point(0, -32768, 0);
    add_point(1, 32767, 1);
    add_point(0, 32767, 0);
    add_point(1, -32768, 1);
    // Fractional slopes that truncate toward zero.
    add_point(0, 0, 0);
    add_point(3, 1, 0);
    add_point(6, 2, 1);
    add_point(0, 0, 0);
    add_point(3, -1, 0);
    add_point(6, -2, 1);
    // Alternating bit patterns.
    add_point(16'h5555, 16'hAAAA, 0);
    add_point(16'hAAAA, 16'h5555, 0);
    add_point(-1, 0, 1);
    // Overfull set: points past the limit, the last one too, are dropped.
    for (int i = 0; i < MAX_POINTS + 6; i++) begin
      add_point(int'($urandom_range(0, 65535)) - 32768,
                int'($urandom_range(0, 65535)) - 32768, i == MAX_POINTS + 5);
    end
    // Random sets, mostly short, a few single points and a few long ones.
    random_points = 0;
    while (random_points < RANDOM_POINTS) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(20, 60);
        default: len = $urandom_range(2, 12);
      endcase
      add_random_set(len);
      random_points += len;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (points_to_send.size() > 0 || s_tvalid || pending_fits.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_fits.size() > 0) begin
      $display("%0t: %0d fits missing, expected slope %0d status %0d, actual none",
               $time, pending_fits.size(), $signed(pending_fits[0].slope),
               pending_fits[0].status);
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
